[rtl/spmd_pkg.sv]
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types, codes and tables of the signal pending mask dispatcher.
// ----------------------------------------------------------------------------
package spmd_pkg;

  localparam int NUM_TASKS_DEF = 64;
  localparam int TASK_IDX_W    = 6;

  localparam logic [4:0]  SIG_KILL    = 5'd9;
  localparam logic [4:0]  SIG_STOP    = 5'd19;
  localparam logic [4:0]  SIG_CHILD   = 5'd17;
  localparam logic [31:0] UNBLOCKABLE = (32'd1 << SIG_KILL) | (32'd1 << SIG_STOP);

  localparam logic [2:0] KIND_SEND     = 3'd0;
  localparam logic [2:0] KIND_DISPATCH = 3'd1;
  localparam logic [2:0] KIND_BLOCK    = 3'd2;
  localparam logic [2:0] KIND_UNBLOCK  = 3'd3;
  localparam logic [2:0] KIND_SETDISP  = 3'd4;

  localparam logic [1:0] DISP_DEFAULT = 2'd0;
  localparam logic [1:0] DISP_IGNORE  = 2'd1;
  localparam logic [1:0] DISP_USER    = 2'd2;
  localparam logic [1:0] DISP_RSVD    = 2'd3;

  localparam logic [1:0] DA_TERM = 2'd0;
  localparam logic [1:0] DA_IGN  = 2'd1;
  localparam logic [1:0] DA_STOP = 2'd2;
  localparam logic [1:0] DA_CONT = 2'd3;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_IGNORED   = 3'd1;
  localparam logic [2:0] ACT_HANDLER   = 3'd2;
  localparam logic [2:0] ACT_CONTINUE  = 3'd3;
  localparam logic [2:0] ACT_TERMINATE = 3'd4;

  // Default action of each signal, signal 31 first.
  localparam logic [31:0][1:0] DFLT_ACT = {
    DA_TERM, DA_TERM, DA_TERM, DA_IGN,  DA_TERM, DA_TERM, DA_TERM, DA_TERM,
    DA_IGN,  DA_STOP, DA_STOP, DA_STOP, DA_STOP, DA_CONT, DA_IGN,  DA_TERM,
    DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM,
    DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM, DA_TERM
  };

  typedef struct packed {
    logic [4:0]  exit_sig;
    logic [63:0] disp;
    logic [31:0] blocked;
    logic [31:0] pending;
  } spmd_entry_t;

  localparam int ENTRY_W = $bits(spmd_entry_t);

  typedef struct packed {
    logic [2:0]            kind;
    logic [TASK_IDX_W-1:0] task_req;
    logic [4:0]            signal;
    logic [31:0]           mask;
    logic [1:0]            disposition;
    logic                  task_exists;
    logic                  task_live;
    logic                  task_asleep;
    logic [TASK_IDX_W-1:0] parent;
    logic                  parent_live;
  } spmd_req_t;

  typedef struct packed {
    logic       status;
    logic [2:0] action;
    logic [4:0] chosen_signal;
    logic       wake;
    logic [1:0] old_disposition;
    logic       parent_notified;
  } spmd_res_t;

  typedef struct packed {
    logic        we;
    logic        notify;
    spmd_entry_t entry;
    spmd_res_t   res;
  } spmd_exec_t;

endpackage

[rtl/spmd_mem.sv]
// ----------------------------------------------------------------------------
// spmd_mem
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module spmd_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/spmd_exec.sv]
// ----------------------------------------------------------------------------
// spmd_exec
// Read-modify-write logic for one task entry: applies a request to the entry
// read from memory and forms the result word.
// ----------------------------------------------------------------------------
module spmd_exec #(
  parameter int NUM_TASKS = spmd_pkg::NUM_TASKS_DEF
) (
  input  spmd_pkg::spmd_req_t   req,
  input  spmd_pkg::spmd_entry_t rd_entry,
  output spmd_pkg::spmd_exec_t  ex
);
  import spmd_pkg::*;

  logic        in_range;
  logic        live;
  logic        par_ok;
  logic [31:0] bit_sel;
  logic [31:0] deliv;
  logic [31:0] lowest;
  logic [4:0]  chosen;
  logic [1:0]  d;
  logic [1:0]  da;
  logic [1:0]  nd;

  assign in_range = 32'(req.task_req) < 32'(NUM_TASKS);
  assign live     = req.task_exists & req.task_live;
  assign par_ok   = (req.parent != '0) && (32'(req.parent) < 32'(NUM_TASKS))
                    && req.parent_live;
  assign bit_sel  = 32'd1 << req.signal;
  assign deliv    = rd_entry.pending & ~rd_entry.blocked & ~32'd1;
  assign lowest   = deliv & (~deliv + 32'd1);
  assign d        = rd_entry.disp[{chosen, 1'b0} +: 2];
  assign da       = DFLT_ACT[chosen];
  assign nd       = (req.disposition == DISP_RSVD) ? DISP_USER : req.disposition;

  always_comb begin
    chosen = '0;
    for (int i = 1; i < 32; i++) begin
      if (lowest[i]) begin
        chosen = chosen | 5'(i);
      end
    end
  end

  always_comb begin
    ex       = '0;
    ex.entry = rd_entry;
    case (req.kind)
      KIND_SEND: begin
        if (!in_range || req.signal == '0 || !live) begin
          ex.res.status = 1'b1;
        end else begin
          ex.we = 1'b1;
          if ((bit_sel & UNBLOCKABLE) != '0 || (rd_entry.blocked & bit_sel) == '0) begin
            ex.entry.pending = rd_entry.pending | bit_sel;
          end
        end
      end
      KIND_DISPATCH: begin
        if (in_range && req.task_exists && chosen != '0) begin
          ex.we                    = 1'b1;
          ex.entry.pending[chosen] = 1'b0;
          ex.res.chosen_signal     = chosen;
          if (d == DISP_IGNORE) begin
            ex.res.action = ACT_IGNORED;
          end else if (d != DISP_DEFAULT) begin
            ex.res.action = ACT_HANDLER;
          end else if (da == DA_IGN) begin
            ex.res.action = ACT_IGNORED;
          end else if (da == DA_CONT) begin
            ex.res.action = ACT_CONTINUE;
            ex.res.wake   = req.task_asleep;
          end else begin
            ex.res.action     = ACT_TERMINATE;
            ex.entry.exit_sig = chosen;
            ex.notify         = par_ok;
          end
        end
      end
      KIND_BLOCK: begin
        if (!in_range) begin
          ex.res.status = 1'b1;
        end else begin
          ex.we            = 1'b1;
          ex.entry.blocked = rd_entry.blocked | (req.mask & ~UNBLOCKABLE);
        end
      end
      KIND_UNBLOCK: begin
        if (!in_range) begin
          ex.res.status = 1'b1;
        end else begin
          ex.we            = 1'b1;
          ex.entry.blocked = rd_entry.blocked & ~req.mask;
        end
      end
      KIND_SETDISP: begin
        if (!in_range || req.signal == '0 || (bit_sel & UNBLOCKABLE) != '0) begin
          ex.res.status = 1'b1;
        end else begin
          ex.we                                  = 1'b1;
          ex.res.old_disposition                 = rd_entry.disp[{req.signal, 1'b0} +: 2];
          ex.entry.disp[{req.signal, 1'b0} +: 2] = nd;
        end
      end
      default: begin
        ex.res.status = 1'b1;
      end
    endcase
  end

endmodule

[rtl/signal_pending_mask_dispatcher_unit.sv]
// ----------------------------------------------------------------------------
// signal_pending_mask_dispatcher_unit
// Per-task signal pending, blocking and disposition state with dispatch.
// ----------------------------------------------------------------------------
// All task state lives in one single-port memory of NUM_TASKS entries. After
// reset a clearing pass zeroes every entry in turn, during which no word is
// taken on the input. Each request word then uses the memory port for a read
// of the task entry, then the modify and write-back. A dispatch that
// terminates a task with a live parent at a nonzero index below NUM_TASKS
// adds a read of the parent entry and, unless the parent blocks SIG_CHILD, a
// write of it. One result word is produced per request; the next request is
// taken only once the current result has been placed in the output register,
// and a result waits while that register is still occupied.
// ----------------------------------------------------------------------------
module signal_pending_mask_dispatcher_unit #(
  parameter int NUM_TASKS = spmd_pkg::NUM_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // task_req[5:0], signal[10:6], mask[42:11], disposition[44:43],
  // task_exists[45], task_live[46], task_asleep[47], parent[53:48],
  // parent_live[54], zero[55]
  input  logic [55:0] in_tdata,
  // kind[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[0], action[3:1], chosen_signal[8:4], wake[9],
  // old_disposition[11:10], parent_notified[12], zero[15:13]
  output logic [15:0] out_tdata
);
  import spmd_pkg::*;

  localparam int AW = $clog2(NUM_TASKS);
  localparam int XW = (AW > TASK_IDX_W) ? AW : TASK_IDX_W;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_PRD, ST_PWR, ST_DONE
  } state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  spmd_res_t   out_res_r, out_res_nxt;
  spmd_res_t   res_r, res_nxt;
  spmd_req_t   req_r, req_nxt;

  spmd_req_t   in_req;
  spmd_exec_t  ex;
  spmd_entry_t rd_entry;
  spmd_entry_t par_entry;
  logic [ENTRY_W-1:0] mem_rdata;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0] mem_addr;
  logic        mem_we;
  logic        mem_re;
  logic        in_acc;
  logic        out_free;
  logic        par_notify;
  logic [XW-1:0] in_task_x;
  logic [XW-1:0] task_x;
  logic [XW-1:0] par_x;

  assign in_req.kind          = in_tuser;
  assign in_req.task_req      = in_tdata[5:0];
  assign in_req.signal        = in_tdata[10:6];
  assign in_req.mask          = in_tdata[42:11];
  assign in_req.disposition   = in_tdata[44:43];
  assign in_req.task_exists   = in_tdata[45];
  assign in_req.task_live     = in_tdata[46];
  assign in_req.task_asleep   = in_tdata[47];
  assign in_req.parent        = in_tdata[53:48];
  assign in_req.parent_live   = in_tdata[54];

  assign in_task_x = XW'(in_req.task_req);
  assign task_x    = XW'(req_r.task_req);
  assign par_x     = XW'(req_r.parent);

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.parent_notified, out_res_r.old_disposition,
                       out_res_r.wake, out_res_r.chosen_signal, out_res_r.action,
                       out_res_r.status};

  assign rd_entry   = spmd_entry_t'(mem_rdata);
  assign par_notify = !rd_entry.blocked[SIG_CHILD];

  always_comb begin
    par_entry                    = rd_entry;
    par_entry.pending[SIG_CHILD] = 1'b1;
  end

  spmd_exec #(
    .NUM_TASKS(NUM_TASKS)
  ) u_exec (
    .req      (req_r),
    .rd_entry (rd_entry),
    .ex       (ex)
  );

  spmd_mem #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_TASKS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = task_x[AW-1:0];
    mem_wdata = ENTRY_W'(ex.entry);
    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        mem_re   = in_acc;
        mem_addr = in_task_x[AW-1:0];
      end
      ST_EXEC: begin
        mem_we = ex.we;
      end
      ST_PRD: begin
        mem_re   = 1'b1;
        mem_addr = par_x[AW-1:0];
      end
      ST_PWR: begin
        mem_we    = par_notify;
        mem_addr  = par_x[AW-1:0];
        mem_wdata = ENTRY_W'(par_entry);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    res_nxt       = res_r;
    req_nxt       = req_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NUM_TASKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_req;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_nxt = ex.res;
        if (ex.notify) begin
          state_nxt = ST_PRD;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = ex.res;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PRD: begin
        state_nxt = ST_PWR;
      end
      ST_PWR: begin
        res_nxt.parent_notified = par_notify;
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_res_nxt                 = res_r;
          out_res_nxt.parent_notified = par_notify;
          state_nxt                   = ST_IDLE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      out_res_r   <= '0;
      res_r       <= '0;
      req_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_res_r   <= out_res_nxt;
      res_r       <= res_nxt;
      req_r       <= req_nxt;
    end
  end

endmodule
